@@ rtl/assert_macros.svh @@
// Assertion macros for the send engine checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CHK_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CHK_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fsse_pkg.sv @@
// Package: codes, constants and controller/datapath link types for the send engine.
`timescale 1ns / 1ps

package fsse_pkg;

    // chunking and progress
    localparam int CHUNK_SHIFT      = 12;
    localparam int CHUNK_BYTES      = 1 << CHUNK_SHIFT;
    localparam int CHUNKS_PER_ROUND = 64;
    localparam logic [47:0] PROGRESS_STEP = 48'd1048576;
    localparam logic [47:0] MASK48  = 48'hFFFF_FFFF_FFFF;
    localparam int CNT_W            = $clog2(CHUNKS_PER_ROUND) + 1;

    // stream word widths
    localparam int S_FIELDS_W = 48 + 32 + 3 + 2 + 2;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 32 + 48 + 13 + 1 + 48 + 3 + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // event codes
    localparam logic [2:0] FN_START    = 3'd0;
    localparam logic [2:0] FN_ANNOUNCE = 3'd1;
    localparam logic [2:0] FN_CTRL     = 3'd2;
    localparam logic [2:0] FN_ERROR    = 3'd3;
    localparam logic [2:0] FN_TICK     = 3'd4;
    localparam logic [2:0] FN_CANCEL   = 3'd5;
    localparam logic [2:0] FN_FETCH    = 3'd6;
    localparam logic [2:0] FN_RESET    = 3'd7;

    // announcement kinds
    localparam logic [2:0] NT_SEND_PEND = 3'd1;
    localparam logic [2:0] NT_ACCEPTED  = 3'd3;
    localparam logic [2:0] NT_REJECTED  = 3'd4;
    localparam logic [2:0] NT_COMPLETE  = 3'd5;
    localparam logic [2:0] NT_CANCELLED = 3'd6;
    localparam logic [2:0] NT_CANC_DISC = 3'd7;

    // control frame kinds
    localparam logic [1:0] FK_ACCEPT = 2'd0;
    localparam logic [1:0] FK_REJECT = 2'd1;
    localparam logic [1:0] FK_CANCEL = 2'd2;

    // error kinds
    localparam logic [1:0] FT_NO_USER   = 2'd0;
    localparam logic [1:0] FT_BAD_STATE = 2'd1;

    // actions
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_INIT      = 3'd1;
    localparam logic [2:0] ACT_CHUNK     = 3'd2;
    localparam logic [2:0] ACT_COMPLETE  = 3'd3;
    localparam logic [2:0] ACT_CANCEL    = 3'd4;
    localparam logic [2:0] ACT_BUSY      = 3'd5;
    localparam logic [2:0] ACT_EMPTY     = 3'd6;
    localparam logic [2:0] ACT_NO_RECORD = 3'd7;

    // transfer phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_AWAIT   = 3'd1;
    localparam logic [2:0] PH_PENDING = 3'd2;
    localparam logic [2:0] PH_ACTIVE  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_WAITC   = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the input word
        logic ev_step;    // run a single-result event
        logic ch_step;    // issue one chunk request
        logic round_end;  // this chunk is the last of the round
    } fsse_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ch_go;      // captured event is a tick with chunks to send
        logic ch_final;   // the chunk being issued reaches the file size
    } fsse_sts_t;

endpackage

@@ rtl/fsse_ctrl.sv @@
// Controller: sequences accept, event execution and chunk rounds; owns output valid.
`timescale 1ns / 1ps

module fsse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  fsse_pkg::fsse_sts_t sts,
    output fsse_pkg::fsse_cmd_t cmd
);
    import fsse_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHUNK
    } state_t;

    state_t           state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_free;
    logic             step;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.round_end = (cnt_reg == CNT_W'(CHUNKS_PER_ROUND - 1));
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    if (sts.ch_go)
                    begin
                        cmd.ch_step = 1'b1;
                        cnt_next    = cnt_reg + 1'b1;
                        state_next  = (cmd.round_end || sts.ch_final) ? S_IDLE : S_CHUNK;
                    end
                    else
                    begin
                        cmd.ev_step = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_CHUNK:
            begin
                if (out_free)
                begin
                    cmd.ch_step = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                    if (cmd.round_end || sts.ch_final)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        step          = cmd.ev_step || cmd.ch_step;
        m_tvalid_next = step || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

@@ rtl/fsse_dpath.sv @@
// Datapath: transfer slot state, event decode, chunk step and output word register.
`timescale 1ns / 1ps

module fsse_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  fsse_pkg::fsse_cmd_t cmd,
    output fsse_pkg::fsse_sts_t sts,
    input  logic [2:0]          func,
    input  logic [47:0]         file_size,
    input  logic [31:0]         tid,
    input  logic [2:0]          notice_kind,
    input  logic [1:0]          frame_kind,
    input  logic [1:0]          fault_kind,
    output logic [2:0]          action,
    output logic [31:0]         out_tid,
    output logic [47:0]         chunk_offset,
    output logic [12:0]         chunk_length,
    output logic                progress_hit,
    output logic [47:0]         bytes_sent,
    output logic [2:0]          phase,
    output logic                sending,
    output logic                last
);
    import fsse_pkg::*;

    // captured input word
    logic [2:0]  func_reg;
    logic [47:0] fsize_reg;
    logic [31:0] tid_reg;
    logic [2:0]  notice_reg;
    logic [1:0]  frame_reg;
    logic [1:0]  fault_reg;

    // slot state
    logic        busy_reg, busy_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] held_reg, held_next;
    logic [47:0] total_reg, total_next;
    logic [47:0] sent_reg, sent_next;
    logic [47:0] mark_reg, mark_next;

    // output word
    logic [2:0]  act_reg, act_next;
    logic [31:0] otid_reg, otid_next;
    logic [47:0] off_reg, off_next;
    logic [12:0] len_reg, len_next;
    logic        hit_reg, hit_next;
    logic [47:0] bsent_reg;
    logic [2:0]  ophase_reg;
    logic        sending_reg, sending_next;
    logic        last_reg, last_next;

    // event path
    logic        match;
    logic        clr;
    logic        ev_busy;
    logic [2:0]  ev_phase;
    logic [31:0] ev_held;
    logic [47:0] ev_total, ev_sent, ev_mark;
    logic [2:0]  ev_act;
    logic [31:0] ev_tid;

    // chunk path
    logic [47:0] ch_off, ch_rem, ch_sent, ch_mark, mark_sat;
    logic        ch_full, ch_hit, ch_final;
    logic [12:0] ch_len;

    assign match = busy_reg && (held_reg == tid_reg);

    always_comb
    begin
        ev_busy  = busy_reg;
        ev_phase = phase_reg;
        ev_held  = held_reg;
        ev_total = total_reg;
        ev_sent  = sent_reg;
        ev_mark  = mark_reg;
        ev_act   = ACT_NONE;
        ev_tid   = '0;
        clr      = 1'b0;
        case (func_reg)
            FN_START:
            begin
                if (busy_reg)
                begin
                    ev_act = ACT_BUSY;
                end
                else if (fsize_reg == '0)
                begin
                    ev_act = ACT_EMPTY;
                end
                else
                begin
                    ev_busy  = 1'b1;
                    ev_phase = PH_AWAIT;
                    ev_held  = '0;
                    ev_total = fsize_reg;
                    ev_sent  = '0;
                    ev_mark  = PROGRESS_STEP;
                    ev_act   = ACT_INIT;
                end
            end
            FN_ANNOUNCE:
            begin
                case (notice_reg)
                    NT_SEND_PEND:
                    begin
                        if (busy_reg && phase_reg == PH_AWAIT)
                        begin
                            ev_held  = tid_reg;
                            ev_phase = PH_PENDING;
                        end
                    end
                    NT_ACCEPTED:
                    begin
                        if (match && phase_reg == PH_PENDING)
                        begin
                            ev_phase = PH_ACTIVE;
                        end
                    end
                    NT_REJECTED, NT_CANCELLED, NT_CANC_DISC:
                    begin
                        clr = match;
                    end
                    NT_COMPLETE:
                    begin
                        clr = match && (phase_reg == PH_WAITC);
                    end
                    default:
                    begin
                        clr = 1'b0;
                    end
                endcase
            end
            FN_CTRL:
            begin
                case (frame_reg)
                    FK_ACCEPT:
                    begin
                        if (match && phase_reg == PH_PENDING)
                        begin
                            ev_phase = PH_ACTIVE;
                        end
                    end
                    FK_REJECT, FK_CANCEL:
                    begin
                        clr = match;
                    end
                    default:
                    begin
                        clr = 1'b0;
                    end
                endcase
            end
            FN_ERROR:
            begin
                case (fault_reg)
                    FT_NO_USER:   clr = busy_reg && (phase_reg == PH_AWAIT);
                    FT_BAD_STATE: clr = busy_reg;
                    default:      clr = 1'b0;
                endcase
            end
            FN_TICK:
            begin
                // an active tick reaches here only with nothing left to send
                if (busy_reg && phase_reg == PH_DONE)
                begin
                    ev_phase = PH_WAITC;
                    ev_act   = ACT_COMPLETE;
                    ev_tid   = held_reg;
                end
                else if (busy_reg && phase_reg == PH_ACTIVE)
                begin
                    ev_phase = PH_DONE;
                end
            end
            FN_CANCEL:
            begin
                ev_tid = tid_reg;
                if (match)
                begin
                    clr    = 1'b1;
                    ev_act = ACT_CANCEL;
                end
                else
                begin
                    ev_act = ACT_NO_RECORD;
                end
            end
            FN_FETCH:
            begin
                if (busy_reg && phase_reg == PH_ACTIVE)
                begin
                    clr    = 1'b1;
                    ev_act = ACT_CANCEL;
                    ev_tid = held_reg;
                end
            end
            default:
            begin
                clr = 1'b1;
            end
        endcase
        if (clr)
        begin
            ev_busy  = 1'b0;
            ev_phase = PH_IDLE;
            ev_held  = '0;
            ev_total = '0;
            ev_sent  = '0;
            ev_mark  = '0;
        end
    end

    // one chunk: align down, clip to the remainder, advance the progress mark at most once
    always_comb
    begin
        ch_off   = {sent_reg[47:CHUNK_SHIFT], {CHUNK_SHIFT{1'b0}}};
        ch_rem   = total_reg - ch_off;
        ch_full  = (ch_rem >= 48'(CHUNK_BYTES));
        ch_len   = ch_full ? 13'(CHUNK_BYTES) : ch_rem[12:0];
        ch_sent  = ch_full ? (ch_off + 48'(CHUNK_BYTES)) : total_reg;
        ch_final = (ch_sent >= total_reg);
        ch_hit   = (ch_sent >= mark_reg);
        mark_sat = ((MASK48 - mark_reg) < PROGRESS_STEP) ? MASK48 : (mark_reg + PROGRESS_STEP);
        ch_mark  = ch_hit ? mark_sat : mark_reg;
    end

    assign sts.ch_go    = (func_reg == FN_TICK) && busy_reg && (phase_reg == PH_ACTIVE)
                          && (sent_reg < total_reg);
    assign sts.ch_final = ch_final;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        total_next = total_reg;
        sent_next  = sent_reg;
        mark_next  = mark_reg;
        act_next   = act_reg;
        otid_next  = otid_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        hit_next   = hit_reg;
        last_next  = last_reg;
        if (cmd.ch_step)
        begin
            sent_next  = ch_sent;
            mark_next  = ch_mark;
            phase_next = ch_final ? PH_DONE : phase_reg;
            act_next   = ACT_CHUNK;
            otid_next  = held_reg;
            off_next   = ch_off;
            len_next   = ch_len;
            hit_next   = ch_hit;
            last_next  = cmd.round_end || ch_final;
        end
        else if (cmd.ev_step)
        begin
            busy_next  = ev_busy;
            phase_next = ev_phase;
            held_next  = ev_held;
            total_next = ev_total;
            sent_next  = ev_sent;
            mark_next  = ev_mark;
            act_next   = ev_act;
            otid_next  = ev_tid;
            off_next   = '0;
            len_next   = '0;
            hit_next   = 1'b0;
            last_next  = 1'b1;
        end
        sending_next = busy_next && (phase_next == PH_ACTIVE || phase_next == PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
            total_reg <= '0;
            sent_reg  <= '0;
            mark_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
            total_reg <= total_next;
            sent_reg  <= sent_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            fsize_reg  <= file_size;
            tid_reg    <= tid;
            notice_reg <= notice_kind;
            frame_reg  <= frame_kind;
            fault_reg  <= fault_kind;
        end
        if (cmd.ev_step || cmd.ch_step)
        begin
            act_reg     <= act_next;
            otid_reg    <= otid_next;
            off_reg     <= off_next;
            len_reg     <= len_next;
            hit_reg     <= hit_next;
            bsent_reg   <= sent_next;
            ophase_reg  <= phase_next;
            sending_reg <= sending_next;
            last_reg    <= last_next;
        end
    end

    assign action       = act_reg;
    assign out_tid      = otid_reg;
    assign chunk_offset = off_reg;
    assign chunk_length = len_reg;
    assign progress_hit = hit_reg;
    assign bytes_sent   = bsent_reg;
    assign phase        = ophase_reg;
    assign sending      = sending_reg;
    assign last         = last_reg;

endmodule

@@ rtl/file_send_session_engine_core.sv @@
// Top level: single-slot chunked file send engine with stream ports.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Word contents
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: file_size, tid, notice, frame, fault
// m_*       out  m_tvalid/m_tready  tuser: action; tdata: result fields; tlast: last result
//
// Flow: an input word is captured in S_IDLE and executed in S_EXEC once the
//   output register is free; a non-tick event gives one result word.
// An active-phase tick gives up to 64 chunk words, one per cycle unless the output
//   stalls, each from the datapath chunk step (48-bit align, clip, sent-count update).
// Reset: rst_n clears the slot and the controller at once; no clearing pass.
// Stalls: m_tready low holds the output word and pauses chunk issue; a new
//   input word can be taken while the last result of the previous one waits.

module file_send_session_engine_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [47:0] file_size, [79:48] tid, [82:80] notice_kind, [84:83] frame_kind,
    // [86:85] fault_kind, [87] zero
    input  logic [fsse_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] func
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] out_tid, [79:32] chunk_offset, [92:80] chunk_length, [93] progress_hit,
    // [141:94] bytes_sent, [144:142] phase, [145] sending, [151:146] zero
    output logic [fsse_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] action
    output logic [2:0]                     m_tuser,
    output logic                           m_tlast
);
    import fsse_pkg::*;

    fsse_cmd_t   cmd;
    fsse_sts_t   sts;

    logic [31:0] out_tid;
    logic [47:0] chunk_offset;
    logic [12:0] chunk_length;
    logic        progress_hit;
    logic [47:0] bytes_sent;
    logic [2:0]  phase;
    logic        sending;

    fsse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fsse_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .func         (s_tuser),
        .file_size    (s_tdata[47:0]),
        .tid          (s_tdata[79:48]),
        .notice_kind  (s_tdata[82:80]),
        .frame_kind   (s_tdata[84:83]),
        .fault_kind   (s_tdata[86:85]),
        .action       (m_tuser),
        .out_tid      (out_tid),
        .chunk_offset (chunk_offset),
        .chunk_length (chunk_length),
        .progress_hit (progress_hit),
        .bytes_sent   (bytes_sent),
        .phase        (phase),
        .sending      (sending),
        .last         (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, sending, phase, bytes_sent,
                      progress_hit, chunk_length, chunk_offset, out_tid};

endmodule

@@ rtl/fsse_checker.sv @@
// Port checker for the send engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsse_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fsse_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [2:0]                     m_tuser,
    input logic                           m_tlast
);
    import fsse_pkg::*;

    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "output word dropped")
    `CHK_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "word changed")
    `CHK_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready, "second word taken")
    `CHK_IMPL(a_single_last, clk, rst_n, m_tvalid && m_tuser != ACT_CHUNK, m_tlast, "not last")
    `CHK_IMPL(a_chunk_send, clk, rst_n, m_tvalid && m_tuser == ACT_CHUNK, m_tdata[145], "idle chunk")

endmodule

bind file_send_session_engine_core fsse_checker u_fsse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
